// File: sv/gspt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspt_pkg
// Types and constants shared by the glyph shelf packer and its bench.
// ----------------------------------------------------------------------------
package gspt_pkg;

	// Table sizes.
	localparam int DIRECT_SLOTS   = 128;
	localparam int OVERFLOW_SLOTS = 128;
	localparam int DIR_AW = (DIRECT_SLOTS > 1) ? $clog2(DIRECT_SLOTS) : 1;
	localparam int OVF_AW = (OVERFLOW_SLOTS > 1) ? $clog2(OVERFLOW_SLOTS) : 1;
	localparam int OVF_CW = $clog2(OVERFLOW_SLOTS + 1);

	// Atlas geometry.
	localparam logic [10:0] POS_MAX    = 11'd2047;
	localparam logic [9:0]  ATLAS_DFLT = 10'd512;

	// Request modes.
	localparam logic [1:0] MODE_NULL   = 2'd0;
	localparam logic [1:0] MODE_PLACE  = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;
	localparam logic [1:0] MODE_CLEAR  = 2'd3;

	// Result status codes.
	localparam logic [2:0] STAT_PLACED   = 3'd0;
	localparam logic [2:0] STAT_SKIPPED  = 3'd1;
	localparam logic [2:0] STAT_NO_ROOM  = 3'd2;
	localparam logic [2:0] STAT_FULL     = 3'd3;
	localparam logic [2:0] STAT_HIT      = 3'd4;
	localparam logic [2:0] STAT_FALLBACK = 3'd5;
	localparam logic [2:0] STAT_MISS     = 3'd6;
	localparam logic [2:0] STAT_CLEARED  = 3'd7;

	// Configuration register indexes.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [20:0] codepoint;
		logic [9:0]  glyph_width;
		logic [9:0]  glyph_height;
		logic        missing_glyph;
		logic        range_start;
	} gspt_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [10:0] pos_x;
		logic [10:0] pos_y;
		logic [9:0]  out_width;
		logic [9:0]  out_height;
		logic [20:0] out_codepoint;
		logic        invalid_glyph;
	} gspt_out_t;

	// One stored glyph record, 64 bits.
	typedef struct packed {
		logic [10:0] x;
		logic [10:0] y;
		logic [9:0]  w;
		logic [9:0]  h;
		logic [20:0] cp;
		logic        invalid;
	} gspt_rec_t;

	localparam int REC_W = $bits(gspt_rec_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DWAIT,
		ST_SCAN
	} gspt_state_t;

endpackage

// File: sv/glyph_shelf_packer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_shelf_packer_table
// Shelf packer for glyph rectangles in an atlas, with a table of placed
// glyphs: direct slots for low codepoints and an overflow store for others.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Transfer
//  request   start, busy, item                start high while busy low
//  result    done, result                     done high for one cycle
//  config    psel, penable, pwrite, paddr,    psel & penable & pwrite
//            pwdata, prdata, pready
//
// A place, null or clear request passes through accept and execute. A direct
// lookup adds a wait for the record RAM read. An overflow lookup reads the
// overflow RAM one entry per cycle and compares each read with the request
// codepoint, ending on a hit or after the last stored entry.
// The result appears the cycle after the last step; busy drops with it.
// Reset clears the cursor, counters and direct valid bits at once; record
// RAMs hold no reset. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module glyph_shelf_packer_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  gspt_pkg::gspt_in_t  item,
	output logic                done,
	output gspt_pkg::gspt_out_t result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import gspt_pkg::*;

	gspt_state_t state_q, state_d;
	gspt_in_t    item_q;

	logic [9:0]  atlas_w_q, atlas_h_q;
	logic [10:0] cx_q, cx_d, cy_q, cy_d;
	logic [9:0]  rh_q, rh_d;
	logic        stop_q, stop_d;
	logic [OVF_CW-1:0] cnt_q, cnt_d;
	logic [DIRECT_SLOTS-1:0] dvalid_q, dvalid_d;
	gspt_rec_t   slot0_q, slot0_d;
	logic [OVF_CW-1:0] rd_idx_q, rd_idx_d;
	logic        pend_q, pend_d;
	gspt_rec_t   found_q, found_d;
	logic        found_v_q, found_v_d;
	logic        done_d;
	gspt_out_t   res_d;

	// RAM ports.
	logic             dir_we, dir_re, ovf_we, ovf_re;
	logic [DIR_AW-1:0] dir_waddr, dir_raddr;
	logic [OVF_AW-1:0] ovf_waddr, ovf_raddr;
	gspt_rec_t        wrec, dir_rdata, ovf_rdata;

	// Request decode and packing arithmetic.
	logic        is_direct, wrap, no_room, stop_eff;
	logic [DIR_AW-1:0] dir_idx;
	logic [11:0] sum_x, sum_y, adv_x_sum, bot;
	logic [10:0] x_eff, y_eff, adv_x;
	logic [9:0]  rh_eff, adv_rh;
	gspt_rec_t   slot0_eff;

	// Build a result from a status and a record.
	function automatic gspt_out_t mk_res(input logic [2:0] st, input gspt_rec_t r);
		gspt_out_t o;
		o.status        = st;
		o.pos_x         = r.x;
		o.pos_y         = r.y;
		o.out_width     = r.w;
		o.out_height    = r.h;
		o.out_codepoint = r.cp;
		o.invalid_glyph = r.invalid;
		return o;
	endfunction

	gspt_ram #(.WIDTH(REC_W), .DEPTH(DIRECT_SLOTS)) u_dir_ram (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (wrec),
		.re    (dir_re),
		.raddr (dir_raddr),
		.rdata (dir_rdata)
	);

	gspt_ram #(.WIDTH(REC_W), .DEPTH(OVERFLOW_SLOTS)) u_ovf_ram (
		.clk   (clk),
		.we    (ovf_we),
		.waddr (ovf_waddr),
		.wdata (wrec),
		.re    (ovf_re),
		.raddr (ovf_raddr),
		.rdata (ovf_rdata)
	);

	// Configuration port; decoding uses the word address bit only.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HEIGHT) ? {22'd0, atlas_h_q} : {22'd0, atlas_w_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_w_q <= ATLAS_DFLT;
			atlas_h_q <= ATLAS_DFLT;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_WIDTH) begin
				atlas_w_q <= pwdata[9:0];
			end else begin
				atlas_h_q <= pwdata[9:0];
			end
		end
	end

	// Shelf arithmetic: row wrap, saturated cursor, height check.
	assign is_direct = item_q.codepoint < 21'(DIRECT_SLOTS);
	assign dir_idx   = item_q.codepoint[DIR_AW-1:0];
	assign stop_eff  = stop_q & ~item_q.range_start;
	assign sum_x     = {1'b0, cx_q} + {2'b00, item_q.glyph_width};
	assign wrap      = sum_x > {2'b00, atlas_w_q};
	assign sum_y     = {1'b0, cy_q} + {2'b00, rh_q};
	assign x_eff     = wrap ? 11'd0 : cx_q;
	assign y_eff     = !wrap ? cy_q : ((sum_y > {1'b0, POS_MAX}) ? POS_MAX : sum_y[10:0]);
	assign rh_eff    = wrap ? 10'd0 : rh_q;
	assign adv_x_sum = {1'b0, x_eff} + {2'b00, item_q.glyph_width};
	assign adv_x     = (adv_x_sum > {1'b0, POS_MAX}) ? POS_MAX : adv_x_sum[10:0];
	assign adv_rh    = (item_q.glyph_height > rh_eff) ? item_q.glyph_height : rh_eff;
	assign bot       = {1'b0, y_eff} + {2'b00, item_q.glyph_height};
	assign no_room   = bot > {2'b00, atlas_h_q};
	assign slot0_eff = dvalid_q[0] ? slot0_q : '0;

	// Record for a placement.
	always_comb begin
		wrec.x       = x_eff;
		wrec.y       = y_eff;
		wrec.w       = item_q.glyph_width;
		wrec.h       = item_q.glyph_height;
		wrec.cp      = (item_q.mode == MODE_NULL) ? 21'd0 : item_q.codepoint;
		wrec.invalid = (item_q.mode == MODE_NULL);
	end

	assign busy = (state_q != ST_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (item_q.mode == MODE_LOOKUP) begin
					state_d = is_direct ? ST_DWAIT : ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DWAIT: state_d = ST_IDLE;
			ST_SCAN: begin
				if (pend_q && (ovf_rdata.cp == item_q.codepoint)) begin
					state_d = ST_IDLE;
				end else if (!pend_q && (rd_idx_q == cnt_q)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Actions per state: table writes, scan control and the result.
	always_comb begin
		cx_d      = cx_q;
		cy_d      = cy_q;
		rh_d      = rh_q;
		stop_d    = stop_q;
		cnt_d     = cnt_q;
		dvalid_d  = dvalid_q;
		slot0_d   = slot0_q;
		rd_idx_d  = rd_idx_q;
		pend_d    = 1'b0;
		found_d   = found_q;
		found_v_d = found_v_q;
		dir_we    = 1'b0;
		dir_waddr = dir_idx;
		dir_re    = 1'b0;
		dir_raddr = dir_idx;
		ovf_we    = 1'b0;
		ovf_waddr = cnt_q[OVF_AW-1:0];
		ovf_re    = 1'b0;
		ovf_raddr = rd_idx_q[OVF_AW-1:0];
		done_d    = 1'b0;
		res_d     = '0;
		case (state_q)
			ST_EXEC: begin
				case (item_q.mode)
					MODE_NULL: begin
						dir_we      = 1'b1;
						dir_waddr   = '0;
						dvalid_d[0] = 1'b1;
						slot0_d     = wrec;
						cx_d        = adv_x;
						cy_d        = y_eff;
						rh_d        = adv_rh;
						done_d      = 1'b1;
						res_d       = mk_res(STAT_PLACED, wrec);
					end
					MODE_PLACE: begin
						stop_d = stop_eff;
						done_d = 1'b1;
						if (stop_eff || item_q.missing_glyph) begin
							res_d.status = STAT_SKIPPED;
						end else begin
							// The row wrap holds even when the glyph is dropped.
							cx_d = x_eff;
							cy_d = y_eff;
							rh_d = rh_eff;
							if (no_room) begin
								stop_d       = 1'b1;
								res_d.status = STAT_NO_ROOM;
							end else if (is_direct || (cnt_q != OVF_CW'(OVERFLOW_SLOTS))) begin
								if (is_direct) begin
									dir_we            = 1'b1;
									dvalid_d[dir_idx] = 1'b1;
									if (dir_idx == '0) begin
										slot0_d = wrec;
									end
								end else begin
									ovf_we = 1'b1;
									cnt_d  = cnt_q + 1'b1;
								end
								cx_d  = adv_x;
								rh_d  = adv_rh;
								res_d = mk_res(STAT_PLACED, wrec);
							end else begin
								res_d.status = STAT_FULL;
							end
						end
					end
					MODE_LOOKUP: begin
						dir_re    = is_direct;
						rd_idx_d  = '0;
						found_v_d = 1'b0;
					end
					MODE_CLEAR: begin
						cx_d         = '0;
						cy_d         = '0;
						rh_d         = '0;
						stop_d       = 1'b0;
						cnt_d        = '0;
						dvalid_d     = '0;
						done_d       = 1'b1;
						res_d.status = STAT_CLEARED;
					end
					default: ;
				endcase
			end
			ST_DWAIT: begin
				done_d = 1'b1;
				if (dvalid_q[dir_idx] && (dir_rdata.cp == item_q.codepoint)) begin
					res_d = mk_res(STAT_HIT, dir_rdata);
				end else begin
					res_d = mk_res(STAT_FALLBACK, slot0_eff);
				end
			end
			ST_SCAN: begin
				// Issue one read per cycle, compare the previous one.
				if (pend_q && (ovf_rdata.cp == item_q.codepoint)) begin
					done_d = 1'b1;
					res_d  = mk_res(STAT_HIT, ovf_rdata);
				end else begin
					if (pend_q && ovf_rdata.invalid) begin
						found_d   = ovf_rdata;
						found_v_d = 1'b1;
					end
					if (rd_idx_q != cnt_q) begin
						ovf_re   = 1'b1;
						pend_d   = 1'b1;
						rd_idx_d = rd_idx_q + 1'b1;
					end else if (!pend_q) begin
						done_d = 1'b1;
						res_d  = mk_res(STAT_MISS, found_v_q ? found_q : slot0_eff);
					end
				end
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cx_q      <= '0;
			cy_q      <= '0;
			rh_q      <= '0;
			stop_q    <= 1'b0;
			cnt_q     <= '0;
			dvalid_q  <= '0;
			rd_idx_q  <= '0;
			pend_q    <= 1'b0;
			found_v_q <= 1'b0;
			done      <= 1'b0;
		end else begin
			state_q   <= state_d;
			cx_q      <= cx_d;
			cy_q      <= cy_d;
			rh_q      <= rh_d;
			stop_q    <= stop_d;
			cnt_q     <= cnt_d;
			dvalid_q  <= dvalid_d;
			rd_idx_q  <= rd_idx_d;
			pend_q    <= pend_d;
			found_v_q <= found_v_d;
			done      <= done_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_q <= item;
		end
		slot0_q <= slot0_d;
		found_q <= found_d;
		result  <= res_d;
	end

endmodule

// File: sv/gspt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspt_ram
// Generic RAM with one write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module gspt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: bench/glyph_shelf_packer_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_shelf_packer_table_tb
// Self-checking bench for the glyph shelf packer. A queue-fed driver sends
// place, null, lookup and clear requests. A monitor keeps its own copy of the
// cursor, the direct slots and the overflow store, predicts each result as
// its request transfers, and compares every result field by field. Atlas
// sizes are changed over the APB port between phases, only while idle.
// ----------------------------------------------------------------------------
module glyph_shelf_packer_table_tb;
	import gspt_pkg::*;

	localparam int CYCLE_LIMIT = 900000;
	localparam int TAIL_CYCLES = 140;
	localparam int CP_MAX      = 1114111;

	// Clock, reset and block ports.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	gspt_in_t    item = '0;
	logic        done;
	gspt_out_t   result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Request queue, results still awaited, and bench bookkeeping.
	gspt_in_t    queued_requests[$];
	gspt_out_t   awaited_results[$];
	logic [20:0] recent_cps[$];
	logic        took_item = 1'b0;
	logic        gaps_on = 1'b1;
	int          gap_left = 0;
	int          err_count = 0;
	int          result_count = 0;
	int          cycle_count = 0;

	// Predicted packer state and configuration.
	int          atlas_w = int'(ATLAS_DFLT);
	int          atlas_h = int'(ATLAS_DFLT);
	int          cur_x = 0;
	int          cur_y = 0;
	int          row_h = 0;
	bit          range_halted = 1'b0;
	int          ovf_used = 0;
	bit          slot_used [DIRECT_SLOTS];
	gspt_rec_t   slot_rec [DIRECT_SLOTS];
	gspt_rec_t   ovf_rec [OVERFLOW_SLOTS];

	glyph_shelf_packer_table u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Start a new row when the glyph would pass the right edge.
	function automatic void wrap_row(int w);
		if (cur_x + w > atlas_w) begin
			cur_y = (cur_y + row_h > int'(POS_MAX)) ? int'(POS_MAX) : cur_y + row_h;
			cur_x = 0;
			row_h = 0;
		end
	endfunction

	// Move the cursor past a placed glyph and grow the row.
	function automatic void advance_cursor(int w, int h);
		cur_x = (cur_x + w > int'(POS_MAX)) ? int'(POS_MAX) : cur_x + w;
		if (h > row_h)
			row_h = h;
	endfunction

	// Record held in slot 0, or an all-zero record when slot 0 is empty.
	function automatic gspt_rec_t null_slot();
		return slot_used[0] ? slot_rec[0] : gspt_rec_t'('0);
	endfunction

	// Apply one request to the predicted state and return its result.
	function automatic gspt_out_t atlas_step(gspt_in_t req);
		gspt_rec_t rec;
		gspt_rec_t fallback;
		bit        have_fallback;
		int        cp;
		int        w;
		int        h;
		cp = int'(req.codepoint);
		w = int'(req.glyph_width);
		h = int'(req.glyph_height);
		have_fallback = 1'b0;
		fallback = '0;
		case (req.mode)
			MODE_NULL: begin
				wrap_row(w);
				rec = '{x: 11'(cur_x), y: 11'(cur_y), w: 10'(w), h: 10'(h),
					cp: 21'd0, invalid: 1'b1};
				slot_rec[0] = rec;
				slot_used[0] = 1'b1;
				advance_cursor(w, h);
				return {STAT_PLACED, rec};
			end
			MODE_PLACE: begin
				if (req.range_start)
					range_halted = 1'b0;
				if (range_halted || req.missing_glyph)
					return {STAT_SKIPPED, 64'd0};
				wrap_row(w);
				if (cur_y + h > atlas_h) begin
					range_halted = 1'b1;
					return {STAT_NO_ROOM, 64'd0};
				end
				rec = '{x: 11'(cur_x), y: 11'(cur_y), w: 10'(w), h: 10'(h),
					cp: req.codepoint, invalid: 1'b0};
				if (cp < DIRECT_SLOTS) begin
					slot_rec[cp] = rec;
					slot_used[cp] = 1'b1;
				end else if (ovf_used < OVERFLOW_SLOTS) begin
					ovf_rec[ovf_used] = rec;
					ovf_used++;
				end else begin
					return {STAT_FULL, 64'd0};
				end
				advance_cursor(w, h);
				return {STAT_PLACED, rec};
			end
			MODE_LOOKUP: begin
				if (cp < DIRECT_SLOTS) begin
					if (slot_used[cp] && slot_rec[cp].cp == req.codepoint)
						return {STAT_HIT, slot_rec[cp]};
					return {STAT_FALLBACK, null_slot()};
				end
				for (int i = 0; i < ovf_used; i++) begin
					if (ovf_rec[i].cp == req.codepoint)
						return {STAT_HIT, ovf_rec[i]};
					if (ovf_rec[i].invalid) begin
						fallback = ovf_rec[i];
						have_fallback = 1'b1;
					end
				end
				return {STAT_MISS, have_fallback ? fallback : null_slot()};
			end
			default: begin
				cur_x = 0;
				cur_y = 0;
				row_h = 0;
				range_halted = 1'b0;
				ovf_used = 0;
				foreach (slot_used[i])
					slot_used[i] = 1'b0;
				return {STAT_CLEARED, 64'd0};
			end
		endcase
	endfunction

	// One line per mismatch, and a count for the final verdict.
	task automatic report_mismatch(string msg);
		err_count++;
		$display("[%0t] ERROR result %0d: %s", $time, result_count, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
	endtask

	// Result checks first, then prediction for a request that transfers
	// at the same edge.
	always @(posedge clk) begin
		gspt_out_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				result_count++;
				if (awaited_results.size() == 0) begin
					report_mismatch("result with nothing awaited");
				end else begin
					want = awaited_results.pop_front();
					check_field("status", 32'(result.status), 32'(want.status));
					check_field("pos_x", 32'(result.pos_x), 32'(want.pos_x));
					check_field("pos_y", 32'(result.pos_y), 32'(want.pos_y));
					check_field("out_width", 32'(result.out_width), 32'(want.out_width));
					check_field("out_height", 32'(result.out_height),
						32'(want.out_height));
					check_field("out_codepoint", 32'(result.out_codepoint),
						32'(want.out_codepoint));
					check_field("invalid_glyph", 32'(result.invalid_glyph),
						32'(want.invalid_glyph));
				end
			end
			if (start && !busy)
				awaited_results.push_back(atlas_step(item));
		end
		took_item <= arst_n && start && !busy;
	end

	// Request driver: holds each request until it transfers, with random
	// gaps that only count down while the block is free.
	always @(negedge clk) begin
		if (!start || took_item) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				if (!busy)
					gap_left <= gap_left - 1;
			end else if (arst_n && queued_requests.size() > 0) begin
				item <= queued_requests.pop_front();
				start <= 1'b1;
				if (gaps_on && $urandom_range(0, 99) < 30)
					gap_left <= $urandom_range(1, 5);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("glyph_shelf_packer_table_tb failed");
			$finish;
		end
	end

	// Queue a request and remember codepoints of place requests for later lookups.
	task automatic send(gspt_in_t req);
		queued_requests.push_back(req);
		if (req.mode == MODE_PLACE) begin
			recent_cps.push_back(req.codepoint);
			if (recent_cps.size() > 64)
				void'(recent_cps.pop_front());
		end
	endtask

	task automatic send_fields(logic [1:0] mode, int cp, int w, int h, bit missing,
			bit rstart);
		gspt_in_t req;
		req = '{mode: mode, codepoint: 21'(cp), glyph_width: 10'(w),
			glyph_height: 10'(h), missing_glyph: missing, range_start: rstart};
		send(req);
	endtask

	// Wait until nothing is queued, in flight or awaited.
	task automatic wait_quiet();
		while (queued_requests.size() != 0 || start || awaited_results.size() != 0
				|| busy)
			@(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(logic reg_idx, int value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {reg_idx, 2'b00};
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == REG_WIDTH)
			atlas_w = value;
		else
			atlas_h = value;
	endtask

	// Random request: mostly well-formed places and lookups, some noise.
	function automatic gspt_in_t rand_item(int dim_max);
		gspt_in_t    req;
		logic [63:0] raw;
		int          pick;
		req = '0;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			req.mode = MODE_NULL;
			req.glyph_width = 10'($urandom_range(0, dim_max));
			req.glyph_height = 10'($urandom_range(0, dim_max));
		end else if (pick < 56) begin
			req.mode = MODE_PLACE;
			case ($urandom_range(0, 2))
				0: req.codepoint = 21'($urandom_range(0, DIRECT_SLOTS - 1));
				1: req.codepoint = 21'($urandom_range(DIRECT_SLOTS, 1200));
				default: req.codepoint = 21'($urandom_range(0, CP_MAX));
			endcase
			if ($urandom_range(0, 9) == 0) begin
				req.glyph_width = 10'($urandom_range(0, 1023));
				req.glyph_height = 10'($urandom_range(0, 1023));
			end else begin
				req.glyph_width = 10'($urandom_range(0, dim_max));
				req.glyph_height = 10'($urandom_range(0, dim_max));
			end
			req.missing_glyph = ($urandom_range(0, 11) == 0);
			req.range_start = ($urandom_range(0, 4) == 0);
		end else if (pick < 92) begin
			req.mode = MODE_LOOKUP;
			if (recent_cps.size() > 0 && $urandom_range(0, 1) == 0)
				req.codepoint = recent_cps[$urandom_range(0, recent_cps.size() - 1)];
			else if ($urandom_range(0, 1) == 0)
				req.codepoint = 21'($urandom_range(0, DIRECT_SLOTS - 1));
			else
				req.codepoint = 21'($urandom_range(0, CP_MAX));
		end else if (pick < 95) begin
			req.mode = MODE_CLEAR;
		end else begin
			raw = {$urandom(), $urandom()};
			req = raw[$bits(gspt_in_t)-1:0];
			if (req.codepoint > CP_MAX)
				req.codepoint = 21'($urandom_range(0, CP_MAX));
		end
		return req;
	endfunction

	// One phase of random traffic at a given atlas size.
	task automatic run_phase(int w, int h, int dim_max, int count);
		wait_quiet();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		send_fields(MODE_CLEAR, 0, 0, 0, 1'b0, 1'b0);
		repeat (count)
			send(rand_item(dim_max));
		wait_quiet();
	endtask

	initial begin
		int w;
		int h;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset atlas size.
		send_fields(MODE_LOOKUP, 5, 0, 0, 1'b0, 1'b0);
		send_fields(MODE_LOOKUP, CP_MAX, 0, 0, 1'b0, 1'b0);
		send_fields(MODE_NULL, 0, 0, 0, 1'b0, 1'b0);
		send_fields(MODE_PLACE, 65, 10, 20, 1'b0, 1'b1);
		send_fields(MODE_PLACE, 66, 8, 8, 1'b1, 1'b0);
		send_fields(MODE_PLACE, 1000, 100, 30, 1'b0, 1'b0);
		send_fields(MODE_LOOKUP, 65, 0, 0, 1'b0, 1'b0);
		send_fields(MODE_LOOKUP, 1000, 0, 0, 1'b0, 1'b0);
		send_fields(MODE_LOOKUP, 66, 0, 0, 1'b0, 1'b0);
		send_fields(MODE_LOOKUP, 2000, 0, 0, 1'b0, 1'b0);
		send_fields(MODE_PLACE, 67, 1023, 5, 1'b0, 1'b0);
		// Too tall: dropped, and the rest of the range is skipped.
		send_fields(MODE_PLACE, 68, 1, 1023, 1'b0, 1'b0);
		send_fields(MODE_PLACE, 69, 1, 1, 1'b0, 1'b0);
		send_fields(MODE_PLACE, 70, 1, 1, 1'b0, 1'b1);
		// Repeated null glyphs wrap without a height check.
		send_fields(MODE_NULL, 0, 1023, 1023, 1'b0, 1'b0);
		send_fields(MODE_NULL, 0, 600, 0, 1'b0, 1'b0);
		send_fields(MODE_LOOKUP, 0, 0, 0, 1'b0, 1'b0);
		send_fields(MODE_PLACE, DIRECT_SLOTS - 1, 0, 0, 1'b0, 1'b1);
		send_fields(MODE_PLACE, DIRECT_SLOTS, 0, 0, 1'b0, 1'b1);
		send_fields(MODE_LOOKUP, DIRECT_SLOTS - 1, 0, 0, 1'b0, 1'b0);
		send_fields(MODE_LOOKUP, DIRECT_SLOTS, 0, 0, 1'b0, 1'b0);
		send_fields(MODE_PLACE, CP_MAX, 5, 5, 1'b0, 1'b1);
		send_fields(MODE_CLEAR, 0, 0, 0, 1'b0, 1'b0);
		send_fields(MODE_LOOKUP, 65, 0, 0, 1'b0, 1'b0);
		send_fields(MODE_PLACE, 0, 3, 3, 1'b0, 1'b1);
		send_fields(MODE_LOOKUP, 0, 0, 0, 1'b0, 1'b0);
		wait_quiet();

		// Fill the overflow store past its end, then search it.
		write_reg(REG_WIDTH, 1023);
		write_reg(REG_HEIGHT, 1023);
		send_fields(MODE_CLEAR, 0, 0, 0, 1'b0, 1'b0);
		for (int i = 0; i < OVERFLOW_SLOTS + 4; i++)
			send_fields(MODE_PLACE, 1000 + i, $urandom_range(0, 3), $urandom_range(0, 3),
				1'b0, (i == 0));
		for (int i = 0; i < 40; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_fields(MODE_LOOKUP, $urandom_range(DIRECT_SLOTS, CP_MAX), 0, 0,
					1'b0, 1'b0);
			else
				send_fields(MODE_LOOKUP, 1000 + $urandom_range(0, OVERFLOW_SLOTS + 3),
					0, 0, 1'b0, 1'b0);
		end
		wait_quiet();

		// Extreme atlas sizes.
		run_phase(1, 1, 2, 120);
		run_phase(1023, 1, 8, 100);
		run_phase(1, 1023, 8, 100);

		// Random atlas sizes.
		repeat (4) begin
			w = $urandom_range(16, 1023);
			h = $urandom_range(16, 1023);
			run_phase(w, h, ((w < h) ? w : h) / 6 + 1, 150);
		end

		// Back-to-back traffic at the default size to finish.
		gaps_on = 1'b0;
		run_phase(int'(ATLAS_DFLT), int'(ATLAS_DFLT), 40, 100);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("glyph_shelf_packer_table_tb passed");
		else
			$display("glyph_shelf_packer_table_tb failed");
		$finish;
	end

endmodule
